>>> sv/assert_macros.svh
// Assertion macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising clock edge out of reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property with reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Constants and functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int RoundCount = 64;
  localparam int BlockBytes = 64;
  localparam int WordCount  = 8;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;
    logic blk;
  } cmp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_sts_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Compression unit: one SHA-256 round per cycle over a block held in the
// two-entry block memory, message schedule in a 16-word window.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmp_req_t    req,
  output cmp_sts_t    sts,
  output logic [4:0]  rd_word,
  input  word_t       rd_data,
  input  logic [2:0]  h_idx,
  output word_t       h_word,
  input  logic        h_clear
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StAdd   = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic       blk_r;
  word_t      h_r [WordCount];
  word_t      v_r [WordCount];
  word_t      w_r [16];
  word_t      wi, s0, s1, t1, t2;

  // Memory word for round r is fetched in the cycle before its round (rnd_r counts fetches).
  assign rd_word = {(st_r == StIdle) ? req.blk : blk_r, rnd_r[3:0]};
  assign h_word  = h_r[h_idx];

  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    if (rnd_r <= 7'd16) wi = rd_data;
    else                wi = s1 + w_r[9] + s0 + w_r[0];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25)) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(6'(rnd_r - 7'd1)) + wi;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    case (st_r)
      StIdle: begin
        rnd_nxt = 7'd0;
        if (req.start) begin
          st_nxt  = StRound;
          rnd_nxt = 7'd1;
        end
      end
      StRound: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(RoundCount)) st_nxt = StAdd;
      end
      StAdd: begin
        st_nxt  = StIdle;
        rnd_nxt = 7'd0;
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= StIdle;
      rnd_r <= 7'd0;
      blk_r <= 1'b0;
      for (int i = 0; i < WordCount; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
      if (st_r == StIdle && req.start) blk_r <= req.blk;
      if (h_clear) begin
        for (int i = 0; i < WordCount; i++) h_r[i] <= init_hash(3'(i));
      end else if (st_r == StAdd) begin
        for (int i = 0; i < WordCount; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == StIdle) begin
      for (int i = 0; i < WordCount; i++) v_r[i] <= h_r[i];
    end else if (st_r == StRound && rnd_r != 7'd0) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wi;
    end
  end

  assign sts.busy = (st_r != StIdle);
  assign sts.done = (st_r == StAdd);

endmodule

>>> sv/sha_blk_mem.sv
// ----------------------------------------------------------------------------
// sha_blk_mem
// Block memory: two 64-byte block buffers, byte write port, word read port.
// ----------------------------------------------------------------------------
module sha_blk_mem import sha_pkg::*; (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [6:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [4:0] rd_word,
  output word_t      rd_data
);

  logic [7:0] mem0 [32];
  logic [7:0] mem1 [32];
  logic [7:0] mem2 [32];
  logic [7:0] mem3 [32];

  // Byte lane = low two address bits; word address = upper bits.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_addr[1:0])
        2'd0:    mem0[wr_addr[6:2]] <= wr_data;
        2'd1:    mem1[wr_addr[6:2]] <= wr_data;
        2'd2:    mem2[wr_addr[6:2]] <= wr_data;
        default: mem3[wr_addr[6:2]] <= wr_data;
      endcase
    end
    rd_data <= {mem0[rd_word], mem1[rd_word], mem2[rd_word], mem3[rd_word]};
  end

endmodule

>>> sv/sha256_stream_hash.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash
// SHA-256 of a byte stream, one byte per transfer, digest as eight words.
// ----------------------------------------------------------------------------
// Each byte is written into a double-buffered block memory. A full block
// starts the round unit (one round per cycle) on one buffer while bytes fill
// the other, so a long message keeps streaming while blocks compress;
// within a message in_stall rises only when a second block fills before
// the first has started compressing. From an end transfer in_stall holds
// high until the digest has gone out: padding is written one byte a cycle
// unless a pending block has not yet started (9 to 72 bytes), the one or
// two final blocks are compressed, and the eight digest words follow from
// registered state, one per transfer.
module sha256_stream_hash import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] StFill = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;
  localparam logic [2:0] StHold = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic        buf_r, buf_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic        pend_r, pend_nxt;
  logic        pblk_r, pblk_nxt;
  logic        two_r, two_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] bitlen;
  logic        wr_en;
  logic [7:0]  wr_data;
  logic        accept, take, cmp_go, clr;
  cmp_req_t    req;
  cmp_sts_t    sts;
  logic [4:0]  rd_word;
  word_t       rd_data, h_word;

  assign bitlen = {cnt_r, 3'b000};
  assign accept = in_valid && !in_stall;
  assign take   = out_valid && !out_stall;
  assign cmp_go = pend_r && !sts.busy;

  assign req.start = cmp_go;
  assign req.blk   = pblk_r;

  sha_blk_mem u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr({buf_r, fill_r}), .wr_data(wr_data),
    .rd_word(rd_word), .rd_data(rd_data)
  );

  sha_core u_core (
    .clk(clk), .rst_n(rst_n), .req(req), .sts(sts), .rd_word(rd_word),
    .rd_data(rd_data), .h_idx(oidx_r), .h_word(h_word), .h_clear(clr)
  );

  always_comb begin
    in_stall = !(st_r == StFill) || (pend_r && fill_r == 6'd63);
  end

  always_comb begin
    st_nxt   = st_r;
    fill_nxt = fill_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    pblk_nxt = pblk_r;
    two_nxt  = two_r;
    oidx_nxt = oidx_r;
    ov_nxt   = ov_r;
    wr_en    = 1'b0;
    wr_data  = in_data_byte;
    clr      = 1'b0;
    if (cmp_go) pend_nxt = 1'b0;
    case (st_r)
      StFill: begin
        if (accept) begin
          if (in_byte_present) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + 6'd1;
            cnt_nxt  = cnt_r + 61'd1;
            if (fill_r == 6'd63) begin
              pend_nxt = 1'b1;
              pblk_nxt = buf_r;
              buf_nxt  = !buf_r;
            end
          end
          if (in_end_of_message) begin
            st_nxt  = StPad;
            two_nxt = 1'b0;
          end
        end
      end
      StPad: begin
        // Wait for a prior block to leave the pending slot before queuing.
        if (!(pend_r && fill_r == 6'd63 && !cmp_go)) begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + 6'd1;
          if (!two_r) begin
            wr_data = PadByte;
            two_nxt = 1'b1;
            if (fill_r >= LenOffset) begin
              // Length lands in the next block; zero this one out.
              oidx_nxt = 3'd1;
            end else begin
              oidx_nxt = 3'd0;
            end
          end else if (fill_r < LenOffset || oidx_r == 3'd1) begin
            wr_data = 8'h00;
          end else begin
            wr_data = bitlen[{3'd7 - fill_r[2:0], 3'b000} +: 8];
          end
          if (fill_r == 6'd63) begin
            pend_nxt = 1'b1;
            pblk_nxt = buf_r;
            buf_nxt  = !buf_r;
            if (two_nxt && oidx_nxt == 3'd1) oidx_nxt = 3'd0;
            else st_nxt = StWait;
          end
        end
      end
      StWait: begin
        if (!pend_r && sts.done) begin
          st_nxt   = StOut;
          oidx_nxt = 3'd0;
          ov_nxt   = 1'b1;
        end
      end
      StOut: begin
        if (take) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            ov_nxt   = 1'b0;
            st_nxt   = StHold;
          end
        end
      end
      StHold: begin
        clr      = 1'b1;
        st_nxt   = StFill;
        fill_nxt = 6'd0;
        buf_nxt  = 1'b0;
        cnt_nxt  = 61'd0;
        oidx_nxt = 3'd0;
      end
      default: st_nxt = StFill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= StFill;
      fill_r <= 6'd0;
      buf_r  <= 1'b0;
      cnt_r  <= 61'd0;
      pend_r <= 1'b0;
      pblk_r <= 1'b0;
      two_r  <= 1'b0;
      oidx_r <= 3'd0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      pblk_r <= pblk_nxt;
      two_r  <= two_nxt;
      oidx_r <= oidx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_digest_word = h_word;
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

endmodule

>>> sv/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_word_index,
  input logic        out_last_word,
  input logic [31:0] out_digest_word
);

  `CHK_ASSERT(a_last, clk, rst_n, out_valid |-> (out_last_word == (out_word_index == 3'd7)), "last_word mismatch")
  `CHK_ASSERT(a_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_digest_word)), "stalled word changed")
  `CHK_ASSERT(a_next, clk, rst_n, (out_valid && !out_stall && !out_last_word) |=> (out_word_index == $past(out_word_index) + 3'd1), "word order broken")
  `CHK_ASSERT(a_noin, clk, rst_n, out_valid |-> in_stall, "input taken while digest shown")

endmodule

bind sha256_stream_hash sha_checker u_sha_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word_index(out_word_index),
  .out_last_word(out_last_word), .out_digest_word(out_digest_word)
);
